[design/swdt_pkg.sv]
// Shared constants, codes and types for the Super I/O watchdog register block.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package swdt_pkg;

  // Field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned TPM_W    = 24;

  // Default prescaler width and ticks-per-minute after reset
  localparam int unsigned PRESCALE_BITS_DEF = 24;
  localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(60);

  // Beat action codes
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

  // Port select
  localparam logic PORT_INDEX = 1'b0;
  localparam logic PORT_DATA  = 1'b1;

  // Lock sequence stages
  localparam logic [1:0] STG_LOCKED   = 2'd0;
  localparam logic [1:0] STG_KEY_SEEN = 2'd1;
  localparam logic [1:0] STG_OPEN     = 2'd2;

  // Keys, register indexes and device numbers
  localparam logic [BYTE_W-1:0] UNLOCK_KEY  = 8'h87;
  localparam logic [BYTE_W-1:0] LOCK_KEY    = 8'hAA;
  localparam logic [BYTE_W-1:0] REG_DEVICE  = 8'h07;
  localparam logic [BYTE_W-1:0] DEV_WDOG    = 8'h08;
  localparam logic [BYTE_W-1:0] DEV_PINS    = 8'h07;
  localparam logic [BYTE_W-1:0] REG_COUNT   = 8'hF2;
  localparam logic [BYTE_W-1:0] REG_CONTROL = 8'hF3;
  localparam logic [BYTE_W-1:0] REG_STATUS  = 8'hF4;
  localparam logic [BYTE_W-1:0] REG_PINFN   = 8'hE6;
  localparam logic [BYTE_W-1:0] PINFN_RESET = 8'h08;

  // Control from the register file to the minute timer
  typedef struct packed {
    logic              tick;
    logic              reload;
    logic [BYTE_W-1:0] reload_value;
  } swdt_tmr_ctrl_t;

  // Status from the minute timer
  typedef struct packed {
    logic [BYTE_W-1:0] minutes;
    logic              expire;
  } swdt_tmr_stat_t;

endpackage

[design/swdt_if.sv]
// Valid/ready channel interfaces: bus/tick input, result output, config write.
// Depends on swdt_pkg for field widths.
`timescale 1ns / 1ps

interface swdt_in_if
  import swdt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic                port;
  logic [BYTE_W-1:0]   write_data;

  modport source (output valid, action, port, write_data, input ready);
  modport sink   (input valid, action, port, write_data, output ready);
endinterface

interface swdt_out_if
  import swdt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_data;
  logic              expired;
  logic              reset_request;
  logic              unlocked;

  modport source (output valid, read_data, expired, reset_request, unlocked, input ready);
  modport sink   (input valid, read_data, expired, reset_request, unlocked, output ready);
endinterface

interface swdt_cfg_if
  import swdt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [TPM_W-1:0] ticks_per_minute;

  modport source (output valid, ticks_per_minute, input ready);
  modport sink   (input valid, ticks_per_minute, output ready);
endinterface

[design/swdt_timer.sv]
// Minute timer: tick prescaler and minute down counter with expiry pulse.
// Depends on swdt_pkg for the control/status structs.
`timescale 1ns / 1ps

module swdt_timer
  import swdt_pkg::*;
#(
  parameter int unsigned PrescaleBits = PRESCALE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [TPM_W-1:0] ticks_per_minute_i,
  input  swdt_tmr_ctrl_t   ctrl_i,
  output swdt_tmr_stat_t   stat_o
);

  localparam int unsigned CmpW = ((PrescaleBits > TPM_W) ? PrescaleBits : TPM_W) + 1;

  logic [PrescaleBits-1:0] prescale_q, prescale_d;
  logic [BYTE_W-1:0]       minutes_q, minutes_d;
  logic [CmpW-1:0]         tpm_ext, span, period, inc;
  logic                    expire;

  // Effective period: zero counts as one, clamped to the prescaler span
  always_comb begin
    tpm_ext = CmpW'(ticks_per_minute_i);
    span    = CmpW'(1) << PrescaleBits;
    if (tpm_ext == '0) begin
      period = CmpW'(1);
    end else if (tpm_ext > span) begin
      period = span;
    end else begin
      period = tpm_ext;
    end
    inc = CmpW'(prescale_q) + CmpW'(1);
  end

  // Prescaler and counter update
  always_comb begin
    prescale_d = prescale_q;
    minutes_d  = minutes_q;
    expire     = 1'b0;
    if (ctrl_i.reload) begin
      minutes_d  = ctrl_i.reload_value;
      prescale_d = '0;
    end else if (ctrl_i.tick) begin
      if (minutes_q == '0) begin
        prescale_d = '0;
      end else if (inc >= period) begin
        prescale_d = '0;
        minutes_d  = minutes_q - BYTE_W'(1);
        expire     = (minutes_q == BYTE_W'(1));
      end else begin
        prescale_d = inc[PrescaleBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= '0;
      minutes_q  <= '0;
    end else begin
      prescale_q <= prescale_d;
      minutes_q  <= minutes_d;
    end
  end

  assign stat_o.minutes = minutes_q;
  assign stat_o.expire  = expire;

  // A disabled counter keeps the prescaler parked at zero
  a_idle_prescale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    minutes_q == '0 |-> prescale_q == '0)
    else $error("prescaler running while counter disabled");

  // Expiry only comes from a tick stepping the counter from one
  a_expire_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    expire |=> minutes_q == '0 && $past(minutes_q) == BYTE_W'(1))
    else $error("expiry without counter reaching zero");

  // Reload loads the counter and restarts the prescaler
  a_reload_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.reload |=> minutes_q == $past(ctrl_i.reload_value) && prescale_q == '0)
    else $error("reload not applied");

endmodule

[design/superio_watchdog_registers.sv]
// Top level: Super I/O index/data configuration port with minute watchdog.
// Depends on swdt_pkg, swdt_if.sv interfaces and swdt_timer.
//
//   channel | dir | beat contents
//   in_i    | in  | action, port, write_data
//   out_o   | out | read_data, expired, reset_request, unlocked
//   cfg_i   | in  | ticks_per_minute
//
// Each beat is decoded and applied as accepted; its result is in the output
// register on the next cycle. One beat per cycle is sustained unless stalled:
// in_i.ready drops only while the output register is full and stalled.
// cfg_i is always ready. Reset clears all but the result payload; ticks_per_minute returns to 60.
`timescale 1ns / 1ps

module superio_watchdog_registers
  import swdt_pkg::*;
#(
  parameter int unsigned PrescaleBits = PRESCALE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swdt_in_if.sink    in_i,
  swdt_out_if.source out_o,
  swdt_cfg_if.sink   cfg_i
);

  logic [1:0]        stage_q, stage_d;
  logic [BYTE_W-1:0] index_q, index_d;
  logic [BYTE_W-1:0] device_q, device_d;
  logic [BYTE_W-1:0] control_q, control_d;
  logic [BYTE_W-1:0] status_q, status_d;
  logic [BYTE_W-1:0] pinfn_q, pinfn_d;
  logic [TPM_W-1:0]  tpm_q;

  logic              out_valid_q;
  logic [BYTE_W-1:0] rd_data_q, rd_data_d;
  logic              expired_q, reset_req_q, unlocked_q;

  logic              in_acc, open_now;
  logic [BYTE_W-1:0] wdata;
  swdt_tmr_ctrl_t    tmr_ctrl;
  swdt_tmr_stat_t    tmr_stat;

  assign in_acc    = in_i.valid & in_i.ready;
  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign cfg_i.ready = 1'b1;
  assign open_now  = stage_q[1];
  assign wdata     = in_i.write_data;

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q <= TPM_RESET;
    end else if (cfg_i.valid) begin
      tpm_q <= cfg_i.ticks_per_minute;
    end
  end

  swdt_timer #(
    .PrescaleBits(PrescaleBits)
  ) u_timer (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ticks_per_minute_i (tpm_q),
    .ctrl_i             (tmr_ctrl),
    .stat_o             (tmr_stat)
  );

  // Beat decode: lock sequence, register writes, reads, ticks
  always_comb begin
    stage_d   = stage_q;
    index_d   = index_q;
    device_d  = device_q;
    control_d = control_q;
    status_d  = status_q;
    pinfn_d   = pinfn_q;
    rd_data_d = '0;
    tmr_ctrl  = '0;
    if (in_acc) begin
      unique case (in_i.action)
        ACT_WRITE: begin
          if (in_i.port == PORT_INDEX) begin
            if (open_now) begin
              if (wdata == LOCK_KEY) stage_d = STG_LOCKED;
              else                   index_d = wdata;
            end else if (wdata == UNLOCK_KEY) begin
              stage_d = (stage_q == STG_LOCKED) ? STG_KEY_SEEN : STG_OPEN;
            end else begin
              stage_d = STG_LOCKED;
            end
          end else if (open_now) begin
            if (index_q == REG_DEVICE) begin
              device_d = wdata;
            end else if (device_q == DEV_WDOG) begin
              unique case (index_q)
                REG_COUNT: begin
                  tmr_ctrl.reload       = 1'b1;
                  tmr_ctrl.reload_value = wdata;
                end
                REG_CONTROL: control_d = wdata;
                REG_STATUS:  status_d  = {wdata[BYTE_W-1:1], status_q[0] & wdata[0]};
                default: ;
              endcase
            end else if (device_q == DEV_PINS && index_q == REG_PINFN) begin
              pinfn_d = wdata;
            end
          end
        end
        ACT_READ: begin
          if (in_i.port == PORT_DATA && open_now) begin
            if (index_q == REG_DEVICE) begin
              rd_data_d = device_q;
            end else if (device_q == DEV_WDOG) begin
              unique case (index_q)
                REG_COUNT:   rd_data_d = tmr_stat.minutes;
                REG_CONTROL: rd_data_d = control_q;
                REG_STATUS:  rd_data_d = status_q;
                default:     rd_data_d = '0;
              endcase
            end else if (device_q == DEV_PINS && index_q == REG_PINFN) begin
              rd_data_d = pinfn_q;
            end
          end
        end
        ACT_TICK: tmr_ctrl.tick = 1'b1;
        default: ;
      endcase
    end
    // Counter reaching zero sets the expired flag
    if (tmr_stat.expire) status_d[0] = 1'b1;
  end

  // Register state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q   <= STG_LOCKED;
      index_q   <= '0;
      device_q  <= '0;
      control_q <= '0;
      status_q  <= '0;
      pinfn_q   <= '0;
    end else begin
      stage_q   <= stage_d;
      index_q   <= index_d;
      device_q  <= device_d;
      control_q <= control_d;
      status_q  <= status_d;
      pinfn_q   <= pinfn_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_data_q   <= rd_data_d;
      expired_q   <= status_d[0];
      reset_req_q <= status_d[0] & (pinfn_d == PINFN_RESET);
      unlocked_q  <= stage_d[1];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.read_data     = rd_data_q;
  assign out_o.expired       = expired_q;
  assign out_o.reset_request = reset_req_q;
  assign out_o.unlocked      = unlocked_q;

  // Reported flag tracks the status register after the beat
  a_expired_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_o.expired == status_q[0])
    else $error("expired output out of step with status");

  // Reset request never without the expired flag
  a_req_needs_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_o.reset_request |-> out_o.expired)
    else $error("reset request without expiry");

  // Nonzero read data only comes from an unlocked port
  a_read_unlocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_o.read_data != '0 |-> out_o.unlocked)
    else $error("data returned while locked");

  // Lock stage never reaches the unused code
  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q != 2'd3)
    else $error("lock stage out of range");

endmodule
